// ===== sv/assert_macros.svh =====
// Assertion macros used by the converter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== sv/hsfc_pkg.sv =====
// Shared types and constants for the half/single converter
`timescale 1ns / 1ps
package hsfc_pkg;
   localparam logic CMD_NARROW = 1'b0;
   localparam logic CMD_WIDEN  = 1'b1;
   localparam logic [11:0] ROUND_BIAS = 12'hFFF;

   // Stage 1 to stage 2 decoded item
   typedef struct packed {
      logic        cmd;
      logic        sign;
      logic [30:0] mag;
      logic        nan;       // narrow: NaN
      logic        big;       // narrow: overflow / inf / nan
      logic        tiny;      // narrow: below normal half
      logic        zero_out;  // narrow: flushes to zero
      logic [4:0]  sh;        // narrow subnormal shift 14..24 minus 14 ; widen: lead zeros
      logic [4:0]  hexp;      // widen: half exponent
      logic [9:0]  hman;      // widen: half mantissa
   } dec_type;

   // Stage 2 to stage 3 partial result
   typedef struct packed {
      logic        cmd;
      logic        sign;
      logic [31:0] base;      // result without rounding increment
      logic        inc;       // add one (narrow rounding)
   } mid_type;
endpackage

// ===== sv/hsfc_decode.sv =====
// Stage one: classify the operand
`timescale 1ns / 1ps
module hsfc_decode (
   input  logic                 cmd,
   input  logic [31:0]          operand,
   output hsfc_pkg::dec_type    dec
);
   import hsfc_pkg::*;
   logic [7:0] e;
   logic [9:0] m;
   logic [3:0] lz;
   always_comb begin
      e  = operand[30:23];
      m  = operand[9:0];
      lz = 4'd10;
      // leading zero count of the half mantissa, ten narrow steps
      for (int i = 0; i < 10; i++) begin
         if (m[i]) lz = 4'(9 - i);
      end
      dec = '0;
      dec.cmd = cmd;
      if (cmd == CMD_NARROW) begin
         dec.sign     = operand[31];
         dec.mag      = operand[30:0];
         dec.big      = (e >= 8'd143);
         dec.nan      = (operand[30:0] > 31'h7F800000);
         dec.tiny     = (e < 8'd113);
         dec.zero_out = (e <= 8'd101);
         dec.sh       = 5'(8'd112 - e);
      end else begin
         dec.sign = operand[15];
         dec.hexp = operand[14:10];
         dec.hman = m;
         dec.sh   = {1'b0, lz};
      end
   end
endmodule

// ===== sv/hsfc_shift.sv =====
// Stage two: shift, form base word and rounding increment
`timescale 1ns / 1ps
module hsfc_shift (
   input  hsfc_pkg::dec_type dec,
   output hsfc_pkg::mid_type mid
);
   import hsfc_pkg::*;
   logic [23:0] sig;
   logic [4:0]  s;
   logic [23:0] q;
   logic [23:0] rem;
   logic [23:0] half;
   logic [30:0] adj;
   logic [9:0]  nm;
   logic [7:0]  ew;
   always_comb begin
      sig  = {1'b1, dec.mag[22:0]};
      s    = dec.sh + 5'd14;
      q    = sig >> s;
      rem  = sig & ((24'd1 << s) - 24'd1);
      half = 24'd1 << (s - 5'd1);
      adj  = dec.mag - 31'(32'd112 << 23) + 31'(ROUND_BIAS);
      nm   = 10'(dec.hman << (dec.sh[3:0] + 4'd1));
      ew   = 8'd112 - 8'(dec.sh);
      mid  = '0;
      mid.cmd  = dec.cmd;
      mid.sign = dec.sign;
      if (dec.cmd == CMD_NARROW) begin
         if (dec.big) begin
            mid.base = 32'h7C00;
            if (dec.nan) mid.base[9:0] = dec.mag[22:13] | 10'h200;
         end else if (dec.tiny) begin
            if (!dec.zero_out) begin
               mid.base = 32'(q);
               mid.inc  = (rem > half) || (rem == half && q[0]);
            end
         end else begin
            mid.base = 32'(adj[30:13]);
            mid.inc  = 1'b0;
            // carry of the rounding bit into the kept bits
            if (dec.mag[13] && adj[12:0] == 13'h1FFF) mid.inc = 1'b1;
         end
      end else begin
         if (dec.hexp == 5'd31) begin
            mid.base = {9'h0FF, dec.hman, 13'd0};
            if (dec.hman != 10'd0) mid.base[22] = 1'b1;
         end else if (dec.hexp == 5'd0) begin
            if (dec.hman != 10'd0) mid.base = {1'b0, ew, nm, 13'd0};
         end else begin
            mid.base = {1'b0, 8'(dec.hexp) + 8'd112, dec.hman, 13'd0};
         end
      end
   end
endmodule

// ===== sv/half_single_float_converter.sv =====
// Top level of the half/single float converter pipeline
//
//  Channel | Ports     | tdata
//  input   | req_*     | [0] cmd, [32:1] operand, [39:33] zero
//  result  | rsp_*     | [31:0] result
//
// Three register stages (decode, shift, round); one beat per cycle
// sustained while rsp_tready is high. Reset clears the stage valid bits only.
// A stall at the result side holds each full stage up to the first empty one; empty stages still fill.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module half_single_float_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // cmd, operand, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // result
);
   import hsfc_pkg::*;

   logic    v1_ff, v2_ff, v3_ff;
   logic    v1_in, v2_in, v3_in;
   dec_type d_ff, d_in;
   mid_type m_ff, m_in;
   logic [31:0] r_ff, r_in;
   logic    en1, en2, en3;

   hsfc_decode u_dec (.cmd(req_tdata[0]), .operand(req_tdata[32:1]), .dec(d_in));
   hsfc_shift  u_sh  (.dec(d_ff), .mid(m_in));

   // advance where the next stage is free
   assign en3 = !v3_ff || rsp_tready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   assign v1_in = en1 ? req_tvalid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   // final add of the rounding increment
   always_comb begin
      r_in = m_ff.base + 32'(m_ff.inc);
      if (m_ff.cmd == CMD_NARROW) r_in = {16'd0, m_ff.sign, r_in[14:0]};
      else r_in[31] = m_ff.sign;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      if (en1) d_ff <= d_in;
      if (en2) m_ff <= m_in;
      if (en3) r_ff <= r_in;
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = r_ff;

   `ASSERT_CLK(a_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "result dropped under stall")
   `ASSERT_CLK(a_half_hi, clock, reset, (rsp_tvalid && v3_ff && !$past(m_ff.cmd) && $past(en3)) |-> (rsp_tdata[31:16] == 16'd0), "half result upper bits set")
   `ASSERT_CLK(a_ready, clock, reset, (!v1_ff && !v2_ff && !v3_ff) |-> req_tready, "empty pipe not ready")
endmodule
